/* rtl/core/butterworth_biquad_filter_defines.svh */
// Assertion macros shared by the filter's RTL.
`ifndef BUTTERWORTH_BIQUAD_FILTER_DEFINES_SVH
`define BUTTERWORTH_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define BWBQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define BWBQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bwbq_pkg.sv */
package bwbq_pkg;

  localparam int COEF_WIDTH    = 27;
  localparam int COEF_FRAC     = 24;
  localparam int STATE_WIDTH   = 32;
  localparam int PROD_WIDTH    = COEF_WIDTH + STATE_WIDTH;
  localparam int ACC_WIDTH     = 64;
  localparam int RND_WIDTH     = ACC_WIDTH - COEF_FRAC;
  localparam int MODE_WIDTH    = 2;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [MODE_WIDTH-1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_BANDPASS = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_B0 = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_A1   = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_A2   = 2'd3;

  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [STATE_WIDTH-1:0] state_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  typedef struct packed {
    logic   en;
    coef_t  coef;
    state_t data;
  } mul_req_t;

endpackage

/* rtl/core/bwbq_mul.sv */
module bwbq_mul (
  input  logic               clk_i,
  input  bwbq_pkg::mul_req_t req_i,
  output bwbq_pkg::prod_t    prod_o
);
  import bwbq_pkg::*;

  prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.coef * req_i.data;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/butterworth_biquad_filter.sv */
// Second-order biquad in direct form II with a programmable feed-forward pattern.
// Configuration is written over the cfg channel (index 0 mode, 1 gain_b0, 2 fb_a1,
// 3 fb_a2); the user must write it only while no sample is in flight, which the
// block does not enforce itself. cfg_ready_o is always high. A sample request is
// taken on sample_in when valid and ready are both high. The sequencer then runs
// five multiplies through one registered 27 x 32 multiplier and two rounding steps
// in states A1, A2, T, RND, B0, B1, B2, FF and OUT; the result appears on sample_out
// as the input turns ready again, so no sample is taken before the last is through.
// The result sits in an output register, so the next input request is taken while
// an earlier result still waits. If the receiver stalls and the output register is
// still full when a new result is ready, the sequencer holds in its final step and
// the input stays not ready until the waiting result has been taken.
// Reset clears the coefficients, the mode, both delay values and the output valid.
`include "butterworth_biquad_filter_defines.svh"

module butterworth_biquad_filter #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bwbq_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [bwbq_pkg::COEF_WIDTH-1:0]     cfg_data_i,
  input  logic                                sample_in_valid_i,
  output logic                                sample_in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  output logic                                sample_out_valid_o,
  input  logic                                sample_out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o
);
  import bwbq_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_A1   = 4'd1;
  localparam logic [3:0] ST_A2   = 4'd2;
  localparam logic [3:0] ST_T    = 4'd3;
  localparam logic [3:0] ST_RND  = 4'd4;
  localparam logic [3:0] ST_B0   = 4'd5;
  localparam logic [3:0] ST_B1   = 4'd6;
  localparam logic [3:0] ST_B2   = 4'd7;
  localparam logic [3:0] ST_FF   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic signed [RND_WIDTH-1:0] T_MAX = (RND_WIDTH'(1) <<< (STATE_WIDTH - 1)) - 1;
  localparam logic signed [RND_WIDTH-1:0] T_MIN = ~T_MAX;
  localparam logic signed [RND_WIDTH-1:0] Y_MAX = (RND_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [RND_WIDTH-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_WIDTH-1:0] HALF  = ACC_WIDTH'(1) <<< (COEF_FRAC - 1);

  logic [3:0]                    state_q, state_d;
  logic [MODE_WIDTH-1:0]         mode_q;
  coef_t                         gain_b0_q, fb_a1_q, fb_a2_q;
  state_t                        w1_q, w2_q, t_q, t_d;
  logic signed [ACC_WIDTH-1:0]   acc_q, acc_d;
  logic signed [SAMPLE_WIDTH-1:0] y_q, y_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_acc, out_free, t_load, shift_en;
  mul_req_t                      mul_req;
  prod_t                         prod;
  logic signed [ACC_WIDTH-1:0]   prod_ext, prod_dbl, acc_rnd;
  logic signed [RND_WIDTH-1:0]   rnd;

  bwbq_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign cfg_ready_o        = 1'b1;
  assign sample_in_ready_o  = (state_q == ST_IDLE);
  assign sample_out_valid_o = out_valid_q;
  assign sample_out_o       = y_q;

  assign in_acc   = sample_in_valid_i && sample_in_ready_o;
  assign out_free = !out_valid_q || sample_out_ready_i;
  assign prod_ext = ACC_WIDTH'(prod);
  assign prod_dbl = prod_ext <<< 1;
  assign acc_rnd  = (acc_q + HALF) >>> COEF_FRAC;
  assign rnd      = acc_rnd[RND_WIDTH-1:0];

  always_comb begin
    mul_req.en   = 1'b0;
    mul_req.coef = gain_b0_q;
    mul_req.data = w1_q;
    case (state_q)
      ST_A1: begin
        mul_req.en   = 1'b1;
        mul_req.coef = fb_a1_q;
        mul_req.data = w1_q;
      end
      ST_A2: begin
        mul_req.en   = 1'b1;
        mul_req.coef = fb_a2_q;
        mul_req.data = w2_q;
      end
      ST_B0: begin
        mul_req.en   = 1'b1;
        mul_req.coef = gain_b0_q;
        mul_req.data = t_q;
      end
      ST_B1: begin
        mul_req.en   = 1'b1;
        mul_req.coef = gain_b0_q;
        mul_req.data = w1_q;
      end
      ST_B2: begin
        mul_req.en   = 1'b1;
        mul_req.coef = gain_b0_q;
        mul_req.data = w2_q;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (rnd > T_MAX) begin
      t_d = T_MAX[STATE_WIDTH-1:0];
    end else if (rnd < T_MIN) begin
      t_d = T_MIN[STATE_WIDTH-1:0];
    end else begin
      t_d = rnd[STATE_WIDTH-1:0];
    end
    if (rnd > Y_MAX) begin
      y_d = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (rnd < Y_MIN) begin
      y_d = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_d = rnd[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !sample_out_ready_i;
    t_load      = 1'b0;
    shift_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d   = ACC_WIDTH'(sample_in_i) <<< COEF_FRAC;
          state_d = ST_A1;
        end
      end
      ST_A1: begin
        state_d = ST_A2;
      end
      ST_A2: begin
        acc_d   = acc_q - prod_ext;
        state_d = ST_T;
      end
      ST_T: begin
        acc_d   = acc_q - prod_ext;
        state_d = ST_RND;
      end
      ST_RND: begin
        t_load  = 1'b1;
        acc_d   = '0;
        state_d = ST_B0;
      end
      ST_B0: begin
        state_d = ST_B1;
      end
      ST_B1: begin
        acc_d   = acc_q + prod_ext;
        state_d = ST_B2;
      end
      ST_B2: begin
        case (mode_q)
          MODE_HIGHPASS: acc_d = acc_q - prod_dbl;
          MODE_BANDPASS: acc_d = acc_q;
          default:       acc_d = acc_q + prod_dbl;
        endcase
        state_d = ST_FF;
      end
      ST_FF: begin
        if (mode_q == MODE_BANDPASS) begin
          acc_d = acc_q - prod_ext;
        end else begin
          acc_d = acc_q + prod_ext;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          shift_en    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_LOWPASS;
      gain_b0_q   <= '0;
      fb_a1_q     <= '0;
      fb_a2_q     <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE:    mode_q    <= cfg_data_i[MODE_WIDTH-1:0];
          REG_GAIN_B0: gain_b0_q <= cfg_data_i;
          REG_FB_A1:   fb_a1_q   <= cfg_data_i;
          REG_FB_A2:   fb_a2_q   <= cfg_data_i;
          default:     mode_q    <= mode_q;
        endcase
      end
      if (shift_en) begin
        w2_q <= w1_q;
        w1_q <= t_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (t_load) begin
      t_q <= t_d;
    end
    if (shift_en) begin
      y_q <= y_d;
    end
  end

  `BWBQ_ASSERT_NXT(a_busy_after_request, in_acc, !sample_in_ready_o, "input ready right after a request")
  `BWBQ_ASSERT_NXT(a_delay_shift, (state_q == ST_OUT) && out_free, (w2_q == $past(w1_q)) && out_valid_q, "delay line not advanced with the result")
  `BWBQ_ASSERT_NXT(a_stall_holds, (state_q == ST_OUT) && !out_free, state_q == ST_OUT, "sequencer left final step while output was full")
  `BWBQ_ASSERT_IMP(a_out_reg_free, (state_q == ST_OUT) && !out_valid_q, out_free, "empty output register reported as busy")

endmodule

/* tb/biquad_response_checker.sv */
`timescale 1ns / 100ps

module biquad_response_checker
  import bwbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             matched_o
);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  logic [MODE_WIDTH-1:0] mode_q;
  coef_t                 gain_b0_q;
  coef_t                 fb_a1_q;
  coef_t                 fb_a2_q;
  state_t                w1_q;
  state_t                w2_q;
  sample_t               filtered_q[$];

  function automatic longint round_half_up(input longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint saturate(input longint value, input int width);
    longint hi;
    hi = (longint'(1) <<< (width - 1)) - 1;
    if (value > hi) return hi;
    if (value < -hi - 1) return -hi - 1;
    return value;
  endfunction

  // The feedback node is formed first; the feed-forward sum then uses the old delays.
  function automatic sample_t filter_sample(input sample_t x);
    longint node;
    longint ff;
    node = (longint'(x) <<< COEF_FRAC) - longint'(fb_a1_q) * longint'(w1_q)
           - longint'(fb_a2_q) * longint'(w2_q);
    node = saturate(round_half_up(node), STATE_WIDTH);
    case (mode_q)
      MODE_HIGHPASS: ff = node - 2 * longint'(w1_q) + longint'(w2_q);
      MODE_BANDPASS: ff = node - longint'(w2_q);
      default:       ff = node + 2 * longint'(w1_q) + longint'(w2_q);
    endcase
    w2_q = w1_q;
    w1_q = state_t'(node);
    return sample_t'(saturate(round_half_up(longint'(gain_b0_q) * ff), SAMPLE_WIDTH));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sample_t expected;
    if (!rst_ni) begin
      mode_q    = MODE_LOWPASS;
      gain_b0_q = '0;
      fb_a1_q   = '0;
      fb_a2_q   = '0;
      w1_q      = '0;
      w2_q      = '0;
      filtered_q.delete();
      errors_o  = 0;
      pending_o = 0;
      matched_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:    mode_q    = cfg_data_i[MODE_WIDTH-1:0];
          REG_GAIN_B0: gain_b0_q = coef_t'(cfg_data_i);
          REG_FB_A1:   fb_a1_q   = coef_t'(cfg_data_i);
          REG_FB_A2:   fb_a2_q   = coef_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          errors_o++;
          $display("%0t: sample_out %0d arrived, expected none outstanding",
                   $time, out_sample_i);
        end else begin
          expected = filtered_q.pop_front();
          if (out_sample_i !== expected) begin
            errors_o++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, expected, out_sample_i);
          end else begin
            matched_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        filtered_q.push_back(filter_sample(in_sample_i));
      end
      pending_o = filtered_q.size();
    end
  end

endmodule

/* tb/butterworth_biquad_filter_tb.sv */
`timescale 1ns / 100ps

module butterworth_biquad_filter_tb;
  import bwbq_pkg::*;

  localparam int SW                = 24;
  localparam int RANDOM_SETS       = 10;
  localparam int SAMPLES_PER_SET   = 123;
  localparam int MAX_GAP           = 18;
  localparam int SETTLE_CYCLES     = 12;
  localparam int LONG_STALL_AT     = 500;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int Q_ONE             = 1 << COEF_FRAC;
  localparam int COEF_MAX          = (1 << (COEF_WIDTH - 1)) - 1;
  localparam int COEF_MIN          = -(1 << (COEF_WIDTH - 1));
  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i;
  logic [COEF_WIDTH-1:0]    cfg_data_i;
  logic                     sample_in_valid_i;
  logic                     sample_in_ready_o;
  sample_t                  sample_in_i;
  logic                     sample_out_valid_o;
  logic                     sample_out_ready_i;
  sample_t                  sample_out_o;

  int errors;
  int pending;
  int matched;
  int cycle_count = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  bit tx_gapless = 1'b0;

  butterworth_biquad_filter #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .sample_in_valid_i  (sample_in_valid_i),
    .sample_in_ready_o  (sample_in_ready_o),
    .sample_in_i        (sample_in_i),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_ready_i (sample_out_ready_i),
    .sample_out_o       (sample_out_o)
  );

  biquad_response_checker #(
    .SAMPLE_WIDTH(SW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (sample_in_valid_i),
    .in_ready_i   (sample_in_ready_o),
    .in_sample_i  (sample_in_i),
    .out_valid_i  (sample_out_valid_o),
    .out_ready_i  (sample_out_ready_i),
    .out_sample_i (sample_out_o),
    .errors_o     (errors),
    .pending_o    (pending),
    .matched_o    (matched)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [COEF_WIDTH-1:0] word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic load_coefs(input logic [COEF_WIDTH-1:0] mode_word, input coef_t gain,
                            input coef_t a1, input coef_t a2, input logic [3:0] write_mask);
    if (write_mask[REG_MODE]) write_reg(REG_MODE, mode_word);
    if (write_mask[REG_GAIN_B0]) write_reg(REG_GAIN_B0, gain);
    if (write_mask[REG_FB_A1]) write_reg(REG_FB_A1, a1);
    if (write_mask[REG_FB_A2]) write_reg(REG_FB_A2, a2);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input sample_t value);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      sample_in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_in_valid_i <= 1'b1;
    sample_in_i       <= value;
    do @(posedge clk_i); while (!sample_in_ready_o);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_burst(input sample_t burst[$]);
    foreach (burst[i]) send_sample(burst[i]);
  endtask

  task automatic drain();
    sample_in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : receiver
    int gap;
    int quiet_left;
    int taken;
    sample_out_ready_i = 1'b0;
    quiet_left = 0;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == LONG_STALL_AT) begin
        gap = LONG_STALL_CYCLES;
      end else if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
        sample_out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      sample_out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!sample_out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int                    gain_v;
    int                    a1_v;
    int                    a2_v;
    int                    bound;
    int                    pick;
    int                    coef_edges[5];
    logic [MODE_WIDTH-1:0] mode_list[4];
    logic [COEF_WIDTH-1:0] mode_word;
    logic [3:0]            write_mask;

    coef_edges        = '{COEF_MIN, COEF_MAX, 0, -1, 1};
    mode_list         = '{MODE_LOWPASS, MODE_HIGHPASS, MODE_BANDPASS, MODE_UNUSED};
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = REG_MODE;
    cfg_data_i        = '0;
    sample_in_valid_i = 1'b0;
    sample_in_i       = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With every coefficient at zero after reset, the output must stay silent.
    send_burst('{SAMPLE_MAX, SAMPLE_MIN});
    drain();

    load_coefs(COEF_WIDTH'(MODE_LOWPASS), coef_t'(1132462), coef_t'(-19174500),
               coef_t'(6926000), 4'b1111);
    send_burst('{sample_t'(0), sample_t'(1), sample_t'(-1), SAMPLE_MAX, SAMPLE_MAX,
                 SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN});
    drain();

    // Extreme feedback drives the node into saturation within a few samples.
    load_coefs(COEF_WIDTH'(MODE_HIGHPASS), coef_t'(COEF_MAX), coef_t'(COEF_MIN),
               coef_t'(COEF_MIN), 4'b1111);
    send_burst('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN});
    drain();

    load_coefs(COEF_WIDTH'(MODE_BANDPASS), coef_t'(COEF_MIN), coef_t'(COEF_MAX),
               coef_t'(COEF_MAX), 4'b1111);
    send_burst('{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN});
    drain();

    // The unused mode code falls back to lowpass; the upper data bits are ignored.
    load_coefs({{(COEF_WIDTH - MODE_WIDTH){1'b1}}, MODE_UNUSED}, coef_t'(-1), coef_t'(1),
               coef_t'(-1), 4'b1111);
    send_burst('{SAMPLE_MAX, SAMPLE_MIN, sample_t'(1), sample_t'(-1)});
    drain();

    for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
      case ($urandom_range(0, 3))
        0: begin
          a2_v   = $urandom_range(0, Q_ONE - Q_ONE / 16);
          bound  = Q_ONE + a2_v - Q_ONE / 16;
          a1_v   = int'($urandom_range(0, 2 * bound)) - bound;
          gain_v = $urandom_range(0, Q_ONE / 4);
        end
        1: begin
          gain_v = int'($urandom);
          a1_v   = int'($urandom);
          a2_v   = int'($urandom);
        end
        2: begin
          gain_v = coef_edges[$urandom_range(0, 4)];
          a1_v   = coef_edges[$urandom_range(0, 4)];
          a2_v   = coef_edges[$urandom_range(0, 4)];
        end
        default: begin
          a2_v   = Q_ONE - int'($urandom_range(1, 1 << 18));
          a1_v   = 2 * Q_ONE - int'($urandom_range(1 << 19, 1 << 21));
          a1_v   = $urandom_range(0, 1) ? a1_v : -a1_v;
          gain_v = int'($urandom_range(0, 1 << 14));
        end
      endcase
      mode_word = COEF_WIDTH'($urandom);
      mode_word[MODE_WIDTH-1:0] = mode_list[$urandom_range(0, 3)];
      write_mask = (set_idx == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
      tx_gapless = ($urandom_range(0, 3) == 0);
      load_coefs(mode_word, coef_t'(gain_v), coef_t'(a1_v), coef_t'(a2_v), write_mask);
      for (int n = 0; n < SAMPLES_PER_SET; n++) begin
        pick = $urandom_range(0, 15);
        if (pick < 8) begin
          send_sample(sample_t'($urandom));
        end else if (pick < 12) begin
          send_sample(sample_t'(int'($urandom_range(0, 8192)) - 4096));
        end else if (pick == 12) begin
          send_sample(SAMPLE_MAX);
        end else if (pick == 13) begin
          send_sample(SAMPLE_MIN);
        end else if (pick == 14) begin
          send_sample(sample_t'(0));
        end else begin
          send_sample($urandom_range(0, 1) ? sample_t'(1) : sample_t'(-1));
        end
      end
      drain();
    end

    $display("Filtered %0d samples (%0d matched) over %0d coefficient sets, %0d register writes.",
             samples_sent, matched, RANDOM_SETS + 5, reg_writes);
    $display("Included every mode code, node and output saturation, and a %0d-cycle output hold.",
             LONG_STALL_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
